// File: rtl/nbpv_pkg.sv
// Shared types and widths for the pair velocity update block.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package nbpv_pkg;

  // Bit-serial multiplier: wide operand A, narrow operand B walked one bit a cycle.
  localparam int unsigned MUL_AW = 64;
  localparam int unsigned MUL_BW = 33;
  localparam int unsigned MUL_PW = MUL_AW + MUL_BW;

  // Square root: radicand is a sum of three 33-bit squares.
  localparam int unsigned SQ_W   = 66;
  localparam int unsigned ROOT_W = 34;

  // Divider: divisor is a distance or a total mass.
  localparam int unsigned DIV_SW = 34;

  // Width of G * m2 * DT before the fractional shift, and the fraction of G.
  localparam int unsigned DVD_BASE_W = 95;
  localparam int unsigned GRAV_FRAC  = 48;

  typedef struct packed {
    logic               operation;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic        [31:0] mass;
    logic               last_partner;
  } nbpv_in_t;

  typedef struct packed {
    logic signed [31:0] delta_x;
    logic signed [31:0] delta_y;
    logic signed [31:0] delta_z;
    logic               saturated;
  } nbpv_out_t;

endpackage

// File: rtl/nbpv_mul.sv
// Bit-serial shift-add multiplier, one bit of the narrow operand per cycle.
// Depends on nbpv_pkg for operand widths.
`timescale 1ns / 1ps

module nbpv_mul import nbpv_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [MUL_AW-1:0] a_i,
  input  logic [MUL_BW-1:0] b_i,
  output logic              done_o,
  output logic [MUL_PW-1:0] prod_o
);

  localparam int unsigned CW = $clog2(MUL_BW + 1);

  logic [MUL_AW-1:0] a_q;
  logic [MUL_AW-1:0] hi_q;
  logic [MUL_BW-1:0] lo_q;
  logic [CW-1:0]     cnt_q;
  logic              busy_q;
  logic              done_q;
  logic [MUL_AW:0]   sum;

  assign sum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, a_q} : {(MUL_AW + 1){1'b0}});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q    <= '0;
      hi_q   <= '0;
      lo_q   <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      a_q    <= a_i;
      hi_q   <= '0;
      lo_q   <= b_i;
      cnt_q  <= CW'(MUL_BW);
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      hi_q  <= sum[MUL_AW:1];
      lo_q  <= {sum[0], lo_q[MUL_BW-1:1]};
      cnt_q <= cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  assign done_o = done_q;
  assign prod_o = {hi_q, lo_q};

endmodule

// File: rtl/nbpv_div.sv
// Restoring divider, one quotient bit per cycle, quotient shifted into the dividend register.
// Depends on nbpv_pkg for the divisor width.
`timescale 1ns / 1ps

module nbpv_div import nbpv_pkg::*; #(
  parameter int unsigned DW = 111
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DW-1:0]     dvd_i,
  input  logic [DIV_SW-1:0] dsr_i,
  output logic              done_o,
  output logic [DW-1:0]     quot_o
);

  localparam int unsigned CW = $clog2(DW + 1);

  logic [DW-1:0]     dvd_q;
  logic [DIV_SW-1:0] rem_q;
  logic [DIV_SW-1:0] dsr_q;
  logic [CW-1:0]     cnt_q;
  logic              busy_q;
  logic              done_q;
  logic [DIV_SW:0]   trial;
  logic [DIV_SW:0]   diff;
  logic              ge;

  assign trial = {rem_q, dvd_q[DW-1]};
  assign ge    = trial >= {1'b0, dsr_q};
  assign diff  = trial - {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dvd_q  <= '0;
      rem_q  <= '0;
      dsr_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      dvd_q  <= dvd_i;
      rem_q  <= '0;
      dsr_q  <= dsr_i;
      cnt_q  <= CW'(DW);
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DIV_SW-1:0] : trial[DIV_SW-1:0];
      dvd_q <= {dvd_q[DW-2:0], ge};
      cnt_q <= cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  assign done_o = done_q;
  assign quot_o = dvd_q;

endmodule

// File: rtl/nbpv_sqrt.sv
// Digit-by-digit integer square root, two radicand bits and one root bit per cycle.
// Depends on nbpv_pkg for the radicand and root widths.
`timescale 1ns / 1ps

module nbpv_sqrt import nbpv_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [SQ_W-1:0]   rad_i,
  output logic              done_o,
  output logic [ROOT_W-1:0] root_o
);

  localparam int unsigned RW = 2 * ROOT_W;
  localparam int unsigned MW = ROOT_W + 2;
  localparam int unsigned CW = $clog2(ROOT_W + 1);

  logic [RW-1:0]     rad_q;
  logic [MW-1:0]     rem_q;
  logic [ROOT_W-1:0] root_q;
  logic [CW-1:0]     cnt_q;
  logic              busy_q;
  logic              done_q;
  logic [MW+1:0]     rem_t;
  logic [MW+1:0]     trial;
  logic [MW+1:0]     diff;
  logic              ge;

  assign rem_t = {rem_q, rad_q[RW-1:RW-2]};
  assign trial = {2'b00, root_q, 2'b01};
  assign ge    = rem_t >= trial;
  assign diff  = rem_t - trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rad_q  <= '0;
      rem_q  <= '0;
      root_q <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      rad_q  <= RW'(rad_i);
      rem_q  <= '0;
      root_q <= '0;
      cnt_q  <= CW'(ROOT_W);
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      rem_q  <= ge ? diff[MW-1:0] : rem_t[MW-1:0];
      root_q <= {root_q[ROOT_W-2:0], ge};
      rad_q  <= {rad_q[RW-3:0], 2'b00};
      cnt_q  <= cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// File: rtl/nbody_pair_velocity_update_unit.sv
// Top level of the pair velocity update block: sequencer, body state and accumulators.
// Depends on nbpv_pkg, nbpv_mul, nbpv_div and nbpv_sqrt.
`timescale 1ns / 1ps

// A load item (operation 0) stores the body and clears the three velocity-change
// accumulators and the saturation flag. An interact item (operation 1) brings one
// partner and runs through one bit-serial multiplier, one bit-serial divider and
// one square-root unit, all shared. The offsets are squared one axis at a time,
// the square root gives the distance, and then either the gravity path runs (two
// products for G*m2*DT, three divisions by r, then one product per nonzero axis
// unless the factor is oversized) or the collision path runs (a product and a
// division per axis unless the total mass is zero); at zero distance or exactly
// at the collision distance neither runs. The block works on one item at a time
// and takes the next item as soon as the sequencer is idle again, even while a
// finished result still waits in the output register. Only an interact item with
// last_partner set gives a result item.
// Configuration is a plain write port and must only be used while the block is idle.
module nbody_pair_velocity_update_unit import nbpv_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  nbpv_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output nbpv_out_t out_data_o
);

  // The dividend of the gravity factor: G*m2*DT shifted up by the position fraction.
  localparam int unsigned DW = DVD_BASE_W + FRAC_BITS;

  localparam logic [1:0] REG_GRAV = 2'd0;
  localparam logic [1:0] REG_COLL = 2'd1;
  localparam logic [1:0] REG_STEP = 2'd2;

  localparam logic [1:0] LAST_AX = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ,
    ST_SQRT,
    ST_SEL,
    ST_GM,
    ST_GMDT,
    ST_SDIV,
    ST_GTERM,
    ST_CMUL,
    ST_CDIV,
    ST_FIN
  } state_e;

  state_e state_q;
  logic   ph_q;
  logic [1:0] ax_q;
  logic [1:0] dcnt_q;

  logic [31:0] grav_q;
  logic [30:0] coll_q;
  logic [30:0] step_q;

  logic [31:0] bpos_q [3];
  logic [31:0] bvel_q [3];
  logic [31:0] bmass_q;
  logic signed [31:0] acc_q [3];
  logic        sat_q;

  // Partner offsets and velocity differences, two's complement in 33 bits.
  logic [32:0] d_q  [3];
  logic [32:0] dv_q [3];
  logic [31:0] m2_q;
  logic        last_q;
  logic [SQ_W-1:0]   r2_q;
  logic [ROOT_W-1:0] r_q;
  logic [DW-1:0]     s_q;

  logic [MUL_AW-1:0] mul_a_q;
  logic [MUL_BW-1:0] mul_b_q;
  logic              mul_start_q;
  logic [DW-1:0]     div_dvd_q;
  logic [DIV_SW-1:0] div_dsr_q;
  logic              div_start_q;
  logic              sqrt_start_q;

  nbpv_out_t out_q;
  logic      out_valid_q;

  logic              mul_done;
  logic [MUL_PW-1:0] mul_prod;
  logic              div_done;
  logic [DW-1:0]     div_quot;
  logic              sqrt_done;
  logic [ROOT_W-1:0] sqrt_root;

  nbpv_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start_q),
    .a_i     (mul_a_q),
    .b_i     (mul_b_q),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  nbpv_div #(.DW(DW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start_q),
    .dvd_i   (div_dvd_q),
    .dsr_i   (div_dsr_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  nbpv_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start_q),
    .rad_i   (r2_q),
    .done_o  (sqrt_done),
    .root_o  (sqrt_root)
  );

  // Current-axis operands and the term and accumulator update for that axis.
  logic [32:0]        d_cur;
  logic [32:0]        dv_cur;
  logic [32:0]        d_mag;
  logic [32:0]        dv_mag;
  logic [32:0]        total;
  logic               s_big;
  logic               term_neg;
  logic [DW-1:0]      term_mag;
  logic [32:0]        lim;
  logic [32:0]        term_m;
  logic               term_sat;
  logic [32:0]        term;
  logic [33:0]        acc_sum;
  logic signed [31:0] acc_new;
  logic               acc_sat;
  logic               upd_sat;
  logic               in_fire;

  assign in_fire = in_valid_i && in_ready_o;
  assign d_cur   = d_q[ax_q];
  assign dv_cur  = dv_q[ax_q];
  assign d_mag   = d_cur[32] ? (~d_cur + 33'd1) : d_cur;
  assign dv_mag  = dv_cur[32] ? (~dv_cur + 33'd1) : dv_cur;
  assign total   = {1'b0, bmass_q} + {1'b0, m2_q};
  assign s_big   = |s_q[DW-1:MUL_AW];

  always_comb begin
    term_neg = (state_q == ST_CDIV) ? dv_cur[32] : d_cur[32];
    if (state_q == ST_CDIV) begin
      term_mag = div_quot;
    end else if (s_big) begin
      term_mag = {DW{1'b1}};
    end else begin
      term_mag = DW'(mul_prod[MUL_PW-1:GRAV_FRAC]);
    end
    // A negative term may reach one step further than a positive one.
    lim      = term_neg ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
    term_sat = term_mag > DW'(lim);
    term_m   = term_sat ? lim : term_mag[32:0];
    term     = term_neg ? (~term_m + 33'd1) : term_m;

    acc_sum = {{2{acc_q[ax_q][31]}}, acc_q[ax_q]} + {term[32], term};
    acc_sat = 1'b0;
    acc_new = acc_sum[31:0];
    if (!acc_sum[33] && (acc_sum[32] || acc_sum[31])) begin
      acc_new = 32'sh7FFF_FFFF;
      acc_sat = 1'b1;
    end else if (acc_sum[33] && !(acc_sum[32] && acc_sum[31])) begin
      acc_new = 32'sh8000_0000;
      acc_sat = 1'b1;
    end
    upd_sat = term_sat || acc_sat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      ph_q         <= 1'b0;
      ax_q         <= '0;
      dcnt_q       <= '0;
      grav_q       <= 32'd18781;
      coll_q       <= 31'd655;
      step_q       <= 31'd66;
      bpos_q       <= '{default: '0};
      bvel_q       <= '{default: '0};
      bmass_q      <= '0;
      acc_q        <= '{default: '0};
      sat_q        <= 1'b0;
      d_q          <= '{default: '0};
      dv_q         <= '{default: '0};
      m2_q         <= '0;
      last_q       <= 1'b0;
      r2_q         <= '0;
      r_q          <= '0;
      s_q          <= '0;
      mul_a_q      <= '0;
      mul_b_q      <= '0;
      mul_start_q  <= 1'b0;
      div_dvd_q    <= '0;
      div_dsr_q    <= '0;
      div_start_q  <= 1'b0;
      sqrt_start_q <= 1'b0;
      out_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      // A start pulse lasts one cycle; while it is high the issuing step already
      // waits for the unit, so no new start can be raised in the same cycle.
      if (mul_start_q) begin
        mul_start_q <= 1'b0;
      end
      if (div_start_q) begin
        div_start_q <= 1'b0;
      end
      if (sqrt_start_q) begin
        sqrt_start_q <= 1'b0;
      end

      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_GRAV: grav_q <= cfg_data_i;
          REG_COLL: coll_q <= cfg_data_i[30:0];
          REG_STEP: step_q <= cfg_data_i[30:0];
          default:  ;
        endcase
      end

      // A result leaving in the cycle a new one is written is replaced in ST_FIN.
      if (out_valid_q && out_ready_i && !(state_q == ST_FIN && last_q)) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            if (!in_data_i.operation) begin
              bpos_q[0] <= in_data_i.pos_x;
              bpos_q[1] <= in_data_i.pos_y;
              bpos_q[2] <= in_data_i.pos_z;
              bvel_q[0] <= in_data_i.vel_x;
              bvel_q[1] <= in_data_i.vel_y;
              bvel_q[2] <= in_data_i.vel_z;
              bmass_q   <= in_data_i.mass;
              acc_q     <= '{default: '0};
              sat_q     <= 1'b0;
            end else begin
              d_q[0]  <= {in_data_i.pos_x[31], in_data_i.pos_x} - {bpos_q[0][31], bpos_q[0]};
              d_q[1]  <= {in_data_i.pos_y[31], in_data_i.pos_y} - {bpos_q[1][31], bpos_q[1]};
              d_q[2]  <= {in_data_i.pos_z[31], in_data_i.pos_z} - {bpos_q[2][31], bpos_q[2]};
              dv_q[0] <= {in_data_i.vel_x[31], in_data_i.vel_x} - {bvel_q[0][31], bvel_q[0]};
              dv_q[1] <= {in_data_i.vel_y[31], in_data_i.vel_y} - {bvel_q[1][31], bvel_q[1]};
              dv_q[2] <= {in_data_i.vel_z[31], in_data_i.vel_z} - {bvel_q[2][31], bvel_q[2]};
              m2_q    <= in_data_i.mass;
              last_q  <= in_data_i.last_partner;
              r2_q    <= '0;
              ax_q    <= '0;
              ph_q    <= 1'b0;
              state_q <= ST_SQ;
            end
          end
        end

        ST_SQ: begin
          if (!ph_q) begin
            mul_a_q     <= MUL_AW'(d_mag);
            mul_b_q     <= d_mag;
            mul_start_q <= 1'b1;
            ph_q        <= 1'b1;
          end else if (mul_done) begin
            r2_q <= r2_q + mul_prod[SQ_W-1:0];
            ph_q <= 1'b0;
            if (ax_q == LAST_AX) begin
              ax_q    <= '0;
              state_q <= ST_SQRT;
            end else begin
              ax_q <= ax_q + 2'd1;
            end
          end
        end

        ST_SQRT: begin
          if (!ph_q) begin
            sqrt_start_q <= 1'b1;
            ph_q         <= 1'b1;
          end else if (sqrt_done) begin
            r_q     <= sqrt_root;
            ph_q    <= 1'b0;
            state_q <= ST_SEL;
          end
        end

        ST_SEL: begin
          // Exactly at the collision distance, or at zero distance, nothing is added.
          priority if (r_q > ROOT_W'(coll_q)) begin
            state_q <= ST_GM;
          end else if (r_q != '0 && r_q < ROOT_W'(coll_q)) begin
            state_q <= ST_CMUL;
          end else begin
            state_q <= ST_FIN;
          end
        end

        ST_GM: begin
          if (!ph_q) begin
            mul_a_q     <= MUL_AW'(grav_q);
            mul_b_q     <= MUL_BW'(m2_q);
            mul_start_q <= 1'b1;
            ph_q        <= 1'b1;
          end else if (mul_done) begin
            ph_q    <= 1'b0;
            state_q <= ST_GMDT;
          end
        end

        ST_GMDT: begin
          if (!ph_q) begin
            mul_a_q     <= mul_prod[MUL_AW-1:0];
            mul_b_q     <= MUL_BW'(step_q);
            mul_start_q <= 1'b1;
            ph_q        <= 1'b1;
          end else if (mul_done) begin
            s_q     <= {mul_prod[DVD_BASE_W-1:0], {FRAC_BITS{1'b0}}};
            ph_q    <= 1'b0;
            dcnt_q  <= '0;
            state_q <= ST_SDIV;
          end
        end

        ST_SDIV: begin
          // Three successive floor divisions by r give the floor of the division by r cubed.
          if (!ph_q) begin
            div_dvd_q   <= s_q;
            div_dsr_q   <= r_q;
            div_start_q <= 1'b1;
            ph_q        <= 1'b1;
          end else if (div_done) begin
            s_q  <= div_quot;
            ph_q <= 1'b0;
            if (dcnt_q == 2'd2) begin
              ax_q    <= '0;
              state_q <= ST_GTERM;
            end else begin
              dcnt_q <= dcnt_q + 2'd1;
            end
          end
        end

        ST_GTERM: begin
          if (!ph_q) begin
            if (d_cur == '0 || s_big) begin
              // A zero offset adds nothing; an oversized factor saturates the term.
              if (d_cur != '0) begin
                acc_q[ax_q] <= acc_new;
                if (upd_sat) begin
                  sat_q <= 1'b1;
                end
              end
              if (ax_q == LAST_AX) begin
                ax_q    <= '0;
                state_q <= ST_FIN;
              end else begin
                ax_q <= ax_q + 2'd1;
              end
            end else begin
              mul_a_q     <= s_q[MUL_AW-1:0];
              mul_b_q     <= d_mag;
              mul_start_q <= 1'b1;
              ph_q        <= 1'b1;
            end
          end else if (mul_done) begin
            acc_q[ax_q] <= acc_new;
            if (upd_sat) begin
              sat_q <= 1'b1;
            end
            ph_q <= 1'b0;
            if (ax_q == LAST_AX) begin
              ax_q    <= '0;
              state_q <= ST_FIN;
            end else begin
              ax_q <= ax_q + 2'd1;
            end
          end
        end

        ST_CMUL: begin
          if (!ph_q) begin
            if (total == '0) begin
              // Zero total mass gives a zero term without saturation.
              if (ax_q == LAST_AX) begin
                ax_q    <= '0;
                state_q <= ST_FIN;
              end else begin
                ax_q <= ax_q + 2'd1;
              end
            end else begin
              mul_a_q     <= MUL_AW'({m2_q, 1'b0});
              mul_b_q     <= dv_mag;
              mul_start_q <= 1'b1;
              ph_q        <= 1'b1;
            end
          end else if (mul_done) begin
            div_dvd_q   <= DW'(mul_prod[SQ_W-1:0]);
            div_dsr_q   <= DIV_SW'(total);
            div_start_q <= 1'b1;
            ph_q        <= 1'b0;
            state_q     <= ST_CDIV;
          end
        end

        ST_CDIV: begin
          if (div_done) begin
            acc_q[ax_q] <= acc_new;
            if (upd_sat) begin
              sat_q <= 1'b1;
            end
            if (ax_q == LAST_AX) begin
              ax_q    <= '0;
              state_q <= ST_FIN;
            end else begin
              ax_q    <= ax_q + 2'd1;
              state_q <= ST_CMUL;
            end
          end
        end

        ST_FIN: begin
          if (!last_q) begin
            state_q <= ST_IDLE;
          end else if (!out_valid_q || out_ready_i) begin
            out_q.delta_x   <= acc_q[0];
            out_q.delta_y   <= acc_q[1];
            out_q.delta_z   <= acc_q[2];
            out_q.saturated <= sat_q;
            out_valid_q     <= 1'b1;
            state_q         <= ST_IDLE;
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTH
  // A multiplier result only arrives while a step that issued a product waits for it.
  a_mul_ctx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> ph_q && (state_q == ST_SQ || state_q == ST_GM || state_q == ST_GMDT ||
                          state_q == ST_GTERM || state_q == ST_CMUL))
    else $error("multiplier finished outside a waiting step");

  // A divider result only arrives in one of the two division steps.
  a_div_ctx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_SDIV && ph_q) || state_q == ST_CDIV)
    else $error("divider finished outside a division step");

  // A new result item only follows the end of a last partner.
  a_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_FIN && last_q))
    else $error("result item raised without a last partner");
`endif

endmodule

// File: dv/nbody_pair_velocity_update_unit_test.sv
// Self-checking testbench for nbody_pair_velocity_update_unit: random and directed items,
// a bit-accurate velocity-change predictor and a result scoreboard.
// Depends on nbpv_pkg and the RTL of the block.
`timescale 1ns / 1ps

module nbody_pair_velocity_update_unit_test;
  import nbpv_pkg::*;

  localparam int unsigned FRAC = 16;
  localparam int unsigned SETTLE_CYCLES = 1200;  // longer than one gravity interaction
  localparam logic [1:0] REG_GRAV = 2'd0;
  localparam logic [1:0] REG_COLL = 2'd1;
  localparam logic [1:0] REG_STEP = 2'd2;
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_INTERACT = 1'b1;

  // Kinds of partner placement relative to the loaded body.
  typedef enum int {PLACE_NEAR, PLACE_FAR, PLACE_EDGE, PLACE_SAME, PLACE_WILD} place_e;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [1:0] cfg_idx;
  logic [31:0] cfg_data;
  logic in_valid, in_ready;
  nbpv_in_t in_data;
  logic out_valid, out_ready;
  nbpv_out_t out_data;

  nbody_pair_velocity_update_unit #(.FRAC_BITS(FRAC)) i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_data_o(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Predictor copy of the registers and of the body state.
  logic [31:0] grav_k;
  logic [30:0] coll_dist;
  logic [30:0] step_dt;
  longint body_p[3];
  longint body_v[3];
  logic [31:0] body_m;
  longint acc_dv[3];
  logic sat_seen;

  nbpv_in_t pending_items[$];
  nbpv_out_t delta_q[$];
  int unsigned mismatches, results_seen, n_loads, n_grav, n_coll, n_skip;
  logic calm;  // no idling on either side while set

  // Clamp a magnitude to the signed 32-bit range and give the signed term.
  function automatic longint clamp_term(input logic neg, input logic [127:0] mag);
    logic [127:0] lim;
    lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
    if (mag > lim) begin
      sat_seen = 1'b1;
      mag = lim;
    end
    return neg ? -longint'(mag[63:0]) : longint'(mag[63:0]);
  endfunction

  function automatic void add_to_acc(input int axis, input longint term);
    longint s;
    s = acc_dv[axis] + term;
    if (s > 64'sh7FFF_FFFF) begin
      s = 64'sh7FFF_FFFF;
      sat_seen = 1'b1;
    end
    if (s < -64'sh8000_0000) begin
      s = -64'sh8000_0000;
      sat_seen = 1'b1;
    end
    acc_dv[axis] = s;
  endfunction

  function automatic logic [127:0] magnitude(input longint v);
    return v < 0 ? 128'(-v) : 128'(v);
  endfunction

  // Works out the velocity change one accepted item causes, and its result if any.
  function automatic void update_velocity_model(input nbpv_in_t it);
    longint p[3], v[3], d[3];
    logic [127:0] r2, r, t, s, total;
    if (it.operation == OP_LOAD) begin
      body_p = '{longint'(it.pos_x), longint'(it.pos_y), longint'(it.pos_z)};
      body_v = '{longint'(it.vel_x), longint'(it.vel_y), longint'(it.vel_z)};
      body_m = it.mass;
      acc_dv = '{0, 0, 0};
      sat_seen = 1'b0;
      n_loads++;
      return;
    end
    p = '{longint'(it.pos_x), longint'(it.pos_y), longint'(it.pos_z)};
    v = '{longint'(it.vel_x), longint'(it.vel_y), longint'(it.vel_z)};
    r2 = '0;
    for (int a = 0; a < 3; a++) begin
      d[a] = p[a] - body_p[a];
      r2 += magnitude(d[a]) * magnitude(d[a]);
    end
    r = '0;
    for (int b = 33; b >= 0; b--) begin
      t = r | (128'd1 << b);
      if (t * t <= r2) r = t;
    end
    if (r > 128'(coll_dist)) begin
      // Gravity: the partner mass times G and DT over r cubed, 48 fractional bits.
      s = ((128'(grav_k) * 128'(it.mass) * 128'(step_dt)) << FRAC);
      s = s / r / r / r;
      for (int a = 0; a < 3; a++) begin
        if (d[a] != 0) begin
          if (s[127:64] != 0) add_to_acc(a, clamp_term(d[a] < 0, 128'd1 << 64));
          else add_to_acc(a, clamp_term(d[a] < 0, (magnitude(d[a]) * s) >> GRAV_FRAC));
        end
      end
      n_grav++;
    end else if (r != 0 && r < 128'(coll_dist)) begin
      // Elastic collision: 2*m2*(v2-v1)/(m1+m2) per axis; zero total mass adds nothing.
      total = 128'(body_m) + 128'(it.mass);
      for (int a = 0; a < 3; a++) begin
        if (total == 0) begin
          add_to_acc(a, 0);
        end else begin
          add_to_acc(a, clamp_term((v[a] - body_v[a]) < 0,
                     (2 * 128'(it.mass) * magnitude(v[a] - body_v[a])) / total));
        end
      end
      n_coll++;
    end else begin
      n_skip++;
    end
    if (it.last_partner) begin
      delta_q.push_back('{delta_x: acc_dv[0][31:0], delta_y: acc_dv[1][31:0],
                          delta_z: acc_dv[2][31:0], saturated: sat_seen});
    end
  endfunction

  // Driver: presents queued items, holding each until the block takes it.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
    end else begin
      if (in_valid && in_ready) update_velocity_model(in_data);
      if (!in_valid || in_ready) begin
        if (pending_items.size() != 0 && (calm || $urandom_range(0, 99) >= 20)) begin
          in_valid <= 1'b1;
          in_data <= pending_items.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random back-pressure and comparison against the oldest expectation.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || $urandom_range(0, 99) >= 20;
      if (out_valid && out_ready) begin
        results_seen++;
        if (delta_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("ERROR: unexpected result item %p", out_data);
        end else begin
          if (out_data !== delta_q[0]) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("ERROR: result mismatch expected %p actual %p", delta_q[0], out_data);
            end
          end
          void'(delta_q.pop_front());
        end
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    case (idx)
      REG_GRAV: grav_k = val;
      REG_COLL: coll_dist = val[30:0];
      default: step_dt = val[30:0];
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Waits until every queued item is taken and every result has come, then lets an
  // interaction that gives no result finish too.
  task automatic drain();
    while (pending_items.size() != 0 || in_valid || delta_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic nbpv_in_t make_item(input logic op, input longint px, py, pz,
                                         input longint vx, vy, vz,
                                         input logic [31:0] m, input logic last);
    nbpv_in_t it;
    it.operation = op;
    it.pos_x = px[31:0];
    it.pos_y = py[31:0];
    it.pos_z = pz[31:0];
    it.vel_x = vx[31:0];
    it.vel_y = vy[31:0];
    it.vel_z = vz[31:0];
    it.mass = m;
    it.last_partner = last;
    return it;
  endfunction

  function automatic logic [31:0] any_mass();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 3) << 16;
      1: return $urandom_range(0, 255) << 20;
      default: return $urandom;
    endcase
  endfunction

  function automatic longint offset(input longint span);
    return longint'($urandom_range(0, 32'(2 * span))) - span;
  endfunction

  // Queues a partner placed against the body position bp.
  task automatic queue_partner(input longint bp[3], input place_e kind, input logic last);
    longint p[3], span;
    span = coll_dist / 2;
    if (span > 1000000) span = 1000000;
    for (int a = 0; a < 3; a++) begin
      case (kind)
        PLACE_NEAR: p[a] = bp[a] + offset(span);
        PLACE_FAR:  p[a] = bp[a] + offset(longint'(coll_dist) + 64'd4000000);
        PLACE_EDGE: p[a] = bp[a] + ((a == 0) ? longint'(coll_dist) : 0);
        PLACE_SAME: p[a] = bp[a];
        default:    p[a] = longint'(int'($urandom));
      endcase
    end
    pending_items.push_back(make_item(OP_INTERACT, p[0], p[1], p[2],
                            int'($urandom), int'($urandom), int'($urandom), any_mass(), last));
  endtask

  // Mostly a load followed by a few partners; the rest is unstructured noise.
  task automatic queue_random(input int unsigned count);
    longint bp[3];
    int unsigned k, queued;
    queued = 0;
    while (queued < count) begin
      if ($urandom_range(0, 99) < 85) begin
        for (int a = 0; a < 3; a++) begin
          bp[a] = ($urandom_range(0, 3) == 0) ? longint'(int'($urandom))
                                              : longint'(int'($urandom_range(0, 1 << 24)))
                                                - (1 << 23);
        end
        pending_items.push_back(make_item(OP_LOAD, bp[0], bp[1], bp[2], int'($urandom),
                                int'($urandom), int'($urandom), any_mass(), 1'($urandom)));
        k = $urandom_range(1, 6);
        for (int unsigned i = 0; i < k; i++) begin
          queue_partner(bp, place_e'($urandom_range(0, 4)), i == k - 1);
        end
        queued += k + 1;
      end else begin
        pending_items.push_back(make_item(1'($urandom), int'($urandom), int'($urandom),
                                int'($urandom), int'($urandom), int'($urandom),
                                int'($urandom), $urandom, 1'($urandom)));
        queued++;
      end
    end
  endtask

  task automatic set_regs(input logic [31:0] g, input logic [31:0] cd, input logic [31:0] dt);
    write_reg(REG_GRAV, g);
    write_reg(REG_COLL, cd);
    write_reg(REG_STEP, dt);
  endtask

  initial begin
    longint zero3[3];
    zero3 = '{0, 0, 0};
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    grav_k = 32'd18781;
    coll_dist = 31'd655;
    step_dt = 31'd66;
    body_p = '{0, 0, 0};
    body_v = '{0, 0, 0};
    body_m = '0;
    acc_dv = '{0, 0, 0};
    sat_seen = 1'b0;
    calm = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part under the reset settings. A partner before any load meets the
    // zero body.
    pending_items.push_back(make_item(OP_INTERACT, 100, 0, 0, 5000, -5000, 0, 32'hFFFF_FFFF,
                                      1'b1));
    // Load with last_partner set gives nothing.
    pending_items.push_back(make_item(OP_LOAD, 0, 0, 0, 0, 0, 0, 32'h0001_0000, 1'b1));
    queue_partner(zero3, PLACE_SAME, 1'b1);
    queue_partner(zero3, PLACE_EDGE, 1'b1);
    pending_items.push_back(make_item(OP_INTERACT, 300, -200, 100, 64'sh7FFF_FFFF,
                                      -64'sh8000_0000, 0, 32'hFFFF_FFFF, 1'b0));
    pending_items.push_back(make_item(OP_INTERACT, 1, 1, 1, 64'sh7FFF_FFFF,
                                      -64'sh8000_0000, 64'sh7FFF_FFFF, 32'hFFFF_FFFF, 1'b1));
    // Accumulators keep adding after a result.
    pending_items.push_back(make_item(OP_INTERACT, 64'sh7FFF_FFFF, -64'sh8000_0000,
                                      64'sh7FFF_FFFF, 0, 0, 0, 32'hFFFF_FFFF, 1'b1));
    // Zero total mass in a collision.
    pending_items.push_back(make_item(OP_LOAD, -64'sh8000_0000, -64'sh8000_0000,
                                      -64'sh8000_0000, -64'sh8000_0000, 0, 64'sh7FFF_FFFF,
                                      0, 1'b0));
    pending_items.push_back(make_item(OP_INTERACT, -64'sh7FFF_FF00, -64'sh8000_0000,
                                      -64'sh8000_0000, 64'sh7FFF_FFFF, 0, -64'sh8000_0000,
                                      0, 1'b1));
    pending_items.push_back(make_item(OP_INTERACT, 64'sh7FFF_FFFF, 64'sh7FFF_FFFF,
                                      64'sh7FFF_FFFF, 0, 0, 0, 32'hFFFF_FFFF, 1'b1));
    drain();

    // Strong gravity and a huge collision radius; extremes of every register.
    set_regs(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    pending_items.push_back(make_item(OP_LOAD, 0, 0, 0, 0, 0, 0, 32'h0100_0000, 1'b0));
    queue_partner(zero3, PLACE_NEAR, 1'b1);
    pending_items.push_back(make_item(OP_INTERACT, 64'sh7FFF_FFFF, 0, 0, 0, 0, 0,
                                      32'hFFFF_FFFF, 1'b1));
    queue_random(110);
    drain();

    set_regs(32'h0, 32'h0, 32'h0);
    queue_random(110);
    drain();

    // A calm phase with no idling, at strong but not extreme gravity.
    calm = 1'b1;
    set_regs(32'h4000_0000, 32'd262144, 32'd65536);
    queue_random(130);
    drain();
    calm = 1'b0;

    set_regs($urandom, $urandom_range(0, 1 << 22), $urandom);
    queue_random(120);
    drain();

    set_regs(32'd18781, 32'd655, 32'd66);
    queue_random(110);
    drain();

    $display("Covered %0d loads and %0d partners: %0d gravity, %0d collision, %0d no-op.",
             n_loads, n_grav + n_coll + n_skip, n_grav, n_coll, n_skip);
    $display("Checked %0d result items over six register settings; %0d mismatches.",
             results_seen, mismatches);
    if (mismatches == 0 && delta_q.size() == 0) begin
      $display("nbody_pair_velocity_update_unit test passed");
    end else begin
      $display("nbody_pair_velocity_update_unit test failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("nbody_pair_velocity_update_unit test failed");
    $finish;
  end

endmodule
